### src/tiled_bevel_texture_pixel_top_macros.svh
// Assertion helpers for the tiled bevel texture block.
// Both expect clk and arst_n in scope.
`ifndef TILED_BEVEL_TEXTURE_PIXEL_TOP_MACROS_SVH
`define TILED_BEVEL_TEXTURE_PIXEL_TOP_MACROS_SVH

// cond must hold at every edge outside reset
`define TBT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tbt_pkg.sv
package tbt_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int EDGE_BAND_DEF  = 4;

	localparam logic [7:0] TILE_RESET = 8'd32;
	localparam logic [7:0] TILE_MIN   = 8'd4;
	localparam logic [7:0] ALPHA      = 8'hff;

	// Q1.8 constants
	localparam logic [8:0] Q_BASE   = 9'd102;
	localparam logic [8:0] Q_STEP   = 9'd26;
	localparam logic [8:0] Q_ONE    = 9'd256;
	localparam logic [8:0] Q_SHADOW = 9'd102;
	localparam logic [8:0] Q_HIGH   = 9'd333;
	localparam logic [7:0] Q_NOISE  = 8'd77;

	// Tile height is the top two bits of each entry
	localparam logic [7:0] HEIGHT_ROM [256] = '{
		8'd208, 8'd39, 8'd119, 8'd237, 8'd95, 8'd70, 8'd212, 8'd193,
		8'd211, 8'd4, 8'd191, 8'd98, 8'd172, 8'd163, 8'd218, 8'd12,
		8'd58, 8'd73, 8'd25, 8'd249, 8'd62, 8'd135, 8'd86, 8'd227,
		8'd151, 8'd166, 8'd247, 8'd222, 8'd34, 8'd67, 8'd175, 8'd134,
		8'd135, 8'd201, 8'd212, 8'd140, 8'd241, 8'd180, 8'd145, 8'd252,
		8'd74, 8'd167, 8'd166, 8'd4, 8'd16, 8'd95, 8'd215, 8'd153,
		8'd108, 8'd77, 8'd231, 8'd166, 8'd230, 8'd52, 8'd229, 8'd79,
		8'd181, 8'd60, 8'd77, 8'd96, 8'd138, 8'd114, 8'd1, 8'd54,
		8'd108, 8'd48, 8'd78, 8'd90, 8'd28, 8'd63, 8'd100, 8'd58,
		8'd14, 8'd159, 8'd190, 8'd80, 8'd20, 8'd55, 8'd99, 8'd151,
		8'd85, 8'd12, 8'd203, 8'd129, 8'd44, 8'd126, 8'd195, 8'd214,
		8'd102, 8'd19, 8'd20, 8'd67, 8'd44, 8'd164, 8'd227, 8'd162,
		8'd219, 8'd32, 8'd115, 8'd184, 8'd129, 8'd131, 8'd75, 8'd177,
		8'd173, 8'd147, 8'd65, 8'd99, 8'd211, 8'd176, 8'd113, 8'd54,
		8'd36, 8'd255, 8'd86, 8'd93, 8'd243, 8'd182, 8'd108, 8'd149,
		8'd69, 8'd13, 8'd253, 8'd133, 8'd192, 8'd27, 8'd132, 8'd216,
		8'd237, 8'd14, 8'd120, 8'd2, 8'd250, 8'd49, 8'd246, 8'd112,
		8'd9, 8'd16, 8'd236, 8'd231, 8'd164, 8'd80, 8'd90, 8'd173,
		8'd171, 8'd189, 8'd202, 8'd109, 8'd224, 8'd45, 8'd67, 8'd60,
		8'd59, 8'd234, 8'd111, 8'd136, 8'd32, 8'd94, 8'd18, 8'd187,
		8'd8, 8'd44, 8'd122, 8'd237, 8'd116, 8'd248, 8'd240, 8'd67,
		8'd226, 8'd228, 8'd222, 8'd10, 8'd243, 8'd217, 8'd172, 8'd160,
		8'd84, 8'd215, 8'd115, 8'd255, 8'd197, 8'd19, 8'd83, 8'd246,
		8'd122, 8'd246, 8'd239, 8'd108, 8'd137, 8'd130, 8'd59, 8'd49,
		8'd218, 8'd200, 8'd51, 8'd94, 8'd125, 8'd72, 8'd243, 8'd24,
		8'd55, 8'd109, 8'd164, 8'd69, 8'd42, 8'd165, 8'd254, 8'd209,
		8'd221, 8'd10, 8'd187, 8'd185, 8'd127, 8'd29, 8'd83, 8'd150,
		8'd24, 8'd112, 8'd148, 8'd113, 8'd115, 8'd233, 8'd157, 8'd37,
		8'd33, 8'd24, 8'd173, 8'd71, 8'd159, 8'd221, 8'd152, 8'd39,
		8'd160, 8'd214, 8'd188, 8'd78, 8'd164, 8'd76, 8'd139, 8'd254,
		8'd24, 8'd3, 8'd43, 8'd94, 8'd54, 8'd230, 8'd119, 8'd103,
		8'd83, 8'd242, 8'd212, 8'd34, 8'd57, 8'd24, 8'd105, 8'd198
	};

endpackage

### src/tbt_div_cell.sv
// One restoring-division step for both coordinates, registered.
module tbt_div_cell #(
	parameter int CB = tbt_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    divisor,
	input  logic [7:0]    x_rem,
	input  logic [CB-1:0] x_word,
	input  logic [7:0]    y_rem,
	input  logic [CB-1:0] y_word,
	input  logic [7:0]    noise,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    x_rem_out,
	output logic [CB-1:0] x_word_out,
	output logic [7:0]    y_rem_out,
	output logic [CB-1:0] y_word_out,
	output logic [7:0]    noise_out
);

	logic          valid_q;
	logic [7:0]    x_rem_q, y_rem_q, noise_q;
	logic [CB-1:0] x_word_q, y_word_q;
	logic [8:0]    x_trial, y_trial;
	logic          x_fit, y_fit;
	logic [7:0]    x_rem_nx, y_rem_nx;

	// shift the next dividend bit into the remainder; quotient bits fill the low end
	always_comb begin
		x_trial  = {x_rem, x_word[CB-1]};
		y_trial  = {y_rem, y_word[CB-1]};
		x_fit    = x_trial >= {1'b0, divisor};
		y_fit    = y_trial >= {1'b0, divisor};
		x_rem_nx = x_fit ? 8'(x_trial - {1'b0, divisor}) : x_trial[7:0];
		y_rem_nx = y_fit ? 8'(y_trial - {1'b0, divisor}) : y_trial[7:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_rem_q  <= x_rem_nx;
			y_rem_q  <= y_rem_nx;
			x_word_q <= {x_word[CB-2:0], x_fit};
			y_word_q <= {y_word[CB-2:0], y_fit};
			noise_q  <= noise;
		end
	end

	assign out_valid  = valid_q;
	assign x_rem_out  = x_rem_q;
	assign x_word_out = x_word_q;
	assign y_rem_out  = y_rem_q;
	assign y_word_out = y_word_q;
	assign noise_out  = noise_q;

endmodule

### src/tbt_shade.sv
// Height lookup, edge lighting and final shading, two registered stages.
module tbt_shade #(
	parameter int CB = tbt_pkg::COORD_BITS_DEF,
	parameter int EB = tbt_pkg::EDGE_BAND_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    divisor,
	input  logic [CB-1:0] tile_x,
	input  logic [CB-1:0] tile_y,
	input  logic [7:0]    off_x,
	input  logic [7:0]    off_y,
	input  logic [7:0]    noise,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   argb,
	output logic [7:0]    grey
);

	localparam logic [8:0] BAND = 9'(EB);

	logic [7:0]  idx;
	logic [1:0]  h, h_l, h_r, h_u, h_d;
	logic        band_l, band_r, band_u, band_d;
	logic [8:0]  light;
	logic [15:0] noise_prod;
	logic [8:0]  base;
	logic        v_s1, v_s2, rdy_s2;
	logic [8:0]  base_s1, light_s1;
	logic [7:0]  grey_s2;
	logic [17:0] prod;
	logic [9:0]  prod_q8;
	logic [8:0]  clamped;
	logic [7:0]  grey_nx;

	always_comb begin
		idx = tile_x[7:0] + {tile_y[3:0], 4'h0};
		h   = tbt_pkg::HEIGHT_ROM[idx][7:6];
		h_l = tbt_pkg::HEIGHT_ROM[8'(idx - 8'd1)][7:6];
		h_r = tbt_pkg::HEIGHT_ROM[8'(idx + 8'd1)][7:6];
		h_u = tbt_pkg::HEIGHT_ROM[8'(idx - 8'd16)][7:6];
		h_d = tbt_pkg::HEIGHT_ROM[8'(idx + 8'd16)][7:6];

		band_l = {1'b0, off_x} < BAND;
		band_r = ({1'b0, off_x} + BAND) > {1'b0, divisor};
		band_u = {1'b0, off_y} < BAND;
		band_d = ({1'b0, off_y} + BAND) > {1'b0, divisor};

		// later edges override earlier ones
		light = tbt_pkg::Q_ONE;
		if (band_l && h_l < h) light = tbt_pkg::Q_HIGH;
		if (band_l && h_l > h) light = tbt_pkg::Q_SHADOW;
		if (band_r && h_r < h) light = tbt_pkg::Q_HIGH;
		if (band_r && h_r > h) light = tbt_pkg::Q_SHADOW;
		if (band_u && h_u < h) light = tbt_pkg::Q_HIGH;
		if (band_u && h_u > h) light = tbt_pkg::Q_SHADOW;
		if (band_d && h_d < h) light = tbt_pkg::Q_HIGH;
		if (band_d && h_d > h) light = tbt_pkg::Q_SHADOW;

		noise_prod = {8'b0, tbt_pkg::Q_NOISE} * {8'b0, noise};
		base = tbt_pkg::Q_BASE + {1'b0, noise_prod[15:8]} + tbt_pkg::Q_STEP * {7'b0, h};
	end

	always_comb begin
		prod    = {9'b0, base_s1} * {9'b0, light_s1};
		prod_q8 = prod[17:8];
		clamped = (prod_q8 > {1'b0, tbt_pkg::Q_ONE}) ? tbt_pkg::Q_ONE : prod_q8[8:0];
		// 255 * p >> 8 equals p - 1 for every non-zero p up to one
		grey_nx = (clamped == 9'd0) ? 8'd0 : 8'(clamped - 9'd1);
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			base_s1  <= base;
			light_s1 <= light;
		end
		if (v_s1 && rdy_s2) begin
			grey_s2 <= grey_nx;
		end
	end

	assign out_valid = v_s2;
	assign grey      = grey_s2;
	assign argb      = {tbt_pkg::ALPHA, grey_s2, grey_s2, grey_s2};

endmodule

### src/tiled_bevel_texture_pixel_top.sv
// Tiled bevel texture shader: one pixel request per clock in, one opaque grey ARGB
// word per clock out, while the output is not stalled. The coordinate division by the
// tile edge length runs through a row of COORD_BITS registered divider cells, one
// quotient bit each for x and y, followed by a lookup/lighting stage and a
// multiply/clamp stage. Each stage holds its request while stalled and accepts a new
// one as soon as it can hand its own on, so bubbles close up under output stall.
// Tile edge lengths below 4 act as 4. Write the tile edge register only while no
// request is in flight.
module tiled_bevel_texture_pixel_top #(
	parameter int COORD_BITS = tbt_pkg::COORD_BITS_DEF,
	parameter int EDGE_BAND  = tbt_pkg::EDGE_BAND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [7:0]            noise_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           argb_word,
	output logic [7:0]            grey_level
);

	logic [7:0] tile_q;
	logic [7:0] divisor;

	logic                  v     [COORD_BITS+1];
	logic                  r     [COORD_BITS+1];
	logic [7:0]            x_rem [COORD_BITS+1];
	logic [7:0]            y_rem [COORD_BITS+1];
	logic [COORD_BITS-1:0] x_word[COORD_BITS+1];
	logic [COORD_BITS-1:0] y_word[COORD_BITS+1];
	logic [7:0]            nz    [COORD_BITS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= tbt_pkg::TILE_RESET;
		end else if (cfg_valid) begin
			tile_q <= cfg_data;
		end
	end

	assign divisor = (tile_q < tbt_pkg::TILE_MIN) ? tbt_pkg::TILE_MIN : tile_q;

	assign v[0]      = in_valid;
	assign in_stall  = !r[0];
	assign x_rem[0]  = 8'd0;
	assign y_rem[0]  = 8'd0;
	assign x_word[0] = pixel_x;
	assign y_word[0] = pixel_y;
	assign nz[0]     = noise_byte;

	for (genvar i = 0; i < COORD_BITS; i++) begin : g_div
		tbt_div_cell #(.CB(COORD_BITS)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (v[i]),
			.in_ready   (r[i]),
			.divisor    (divisor),
			.x_rem      (x_rem[i]),
			.x_word     (x_word[i]),
			.y_rem      (y_rem[i]),
			.y_word     (y_word[i]),
			.noise      (nz[i]),
			.out_valid  (v[i+1]),
			.out_ready  (r[i+1]),
			.x_rem_out  (x_rem[i+1]),
			.x_word_out (x_word[i+1]),
			.y_rem_out  (y_rem[i+1]),
			.y_word_out (y_word[i+1]),
			.noise_out  (nz[i+1])
		);
	end

	tbt_shade #(.CB(COORD_BITS), .EB(EDGE_BAND)) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v[COORD_BITS]),
		.in_ready  (r[COORD_BITS]),
		.divisor   (divisor),
		.tile_x    (x_word[COORD_BITS]),
		.tile_y    (y_word[COORD_BITS]),
		.off_x     (x_rem[COORD_BITS]),
		.off_y     (y_rem[COORD_BITS]),
		.noise     (nz[COORD_BITS]),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.argb      (argb_word),
		.grey      (grey_level)
	);

endmodule

### src/tbt_checker.sv
`include "tiled_bevel_texture_pixel_top_macros.svh"

module tbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] argb_word,
	input logic [7:0]  grey_level
);

	// a stalled result holds
	`TBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(argb_word), "stalled result changed")

	`TBT_ASSERT_ALWAYS(a_alpha, !out_valid || argb_word[31:24] == 8'hff, "alpha not opaque")

	`TBT_ASSERT_ALWAYS(a_grey_match, !out_valid || (argb_word[23:16] == grey_level && argb_word[15:8] == grey_level && argb_word[7:0] == grey_level), "channels differ from grey level")

	// darkest case is minimum base under shadow
	`TBT_ASSERT_ALWAYS(a_grey_floor, !out_valid || grey_level >= 8'd39, "grey below darkest shade")

endmodule

bind tiled_bevel_texture_pixel_top tbt_checker u_tbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.argb_word  (argb_word),
	.grey_level (grey_level)
);
